// ===== hdl/signed_unsigned_divmod32_unit_assert.svh =====
// Assertion macros for the divider.
// Each macro takes a label, clock, reset and the expressions to check.
`ifndef SIGNED_UNSIGNED_DIVMOD32_UNIT_ASSERT_SVH
`define SIGNED_UNSIGNED_DIVMOD32_UNIT_ASSERT_SVH

`ifndef SYNTH
`define SUDM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
`define SUDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define SUDM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SUDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/sudm_pkg.sv =====
`default_nettype none

package sudm_pkg;

   // width of the operand and result fields on the ports
   localparam int FIELD_W = 32;

   // control that travels with each transaction down the pipeline
   typedef struct packed {
      logic valid;
      logic qneg;    // negate quotient at the end
      logic rneg;    // negate remainder at the end
      logic dz;      // divisor was zero
   } ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/sudm_div_step.sv =====
`default_nettype none

// One restoring shift-subtract step, registered.
module sudm_div_step #(
   parameter int WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  sudm_pkg::ctrl_type  prev_ctrl,
   input  logic [WIDTH-1:0]    prev_rem,
   input  logic [WIDTH-1:0]    prev_acc,
   input  logic [WIDTH-1:0]    prev_den,
   output sudm_pkg::ctrl_type  stage_ctrl,
   output logic [WIDTH-1:0]    stage_rem,
   output logic [WIDTH-1:0]    stage_acc,
   output logic [WIDTH-1:0]    stage_den
);
   import sudm_pkg::*;

   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;
   logic             fits;
   logic [WIDTH-1:0] rem_in;
   logic [WIDTH-1:0] acc_in;

   ctrl_type         ctrl_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] acc_ff;
   logic [WIDTH-1:0] den_ff;

   // shift in next dividend bit; top bit of trial is the carry out of rem
   always_comb begin
      trial  = {prev_rem, prev_acc[WIDTH-1]};
      diff   = trial - {1'b0, prev_den};
      fits   = ~diff[WIDTH];
      rem_in = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      acc_in = {prev_acc[WIDTH-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (enable) begin
         ctrl_ff <= prev_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         den_ff <= prev_den;
      end
   end

   assign stage_ctrl = ctrl_ff;
   assign stage_rem  = rem_ff;
   assign stage_acc  = acc_ff;
   assign stage_den  = den_ff;

endmodule

`default_nettype wire

// ===== hdl/signed_unsigned_divmod32_unit.sv =====
// Pipelined 32-bit divider, unsigned or signed (truncating toward zero).
// Request channel: req_valid/req_stall with req_kind (0 unsigned, 1 signed),
//   req_divisor and req_dividend. A transaction is taken when req_valid is
//   high and req_stall is low.
// Response channel: rsp_valid/rsp_stall with rsp_quotient, rsp_remainder and
//   rsp_divide_by_zero. A zero divisor gives zero quotient and remainder with
//   the flag set. In signed mode the minimum value over -1 wraps.
// Throughput: one transaction per cycle while req_stall is low. Pipeline: one
//   operand stage, WIDTH restoring steps (one quotient bit per stage), then the
//   sign-fix logic that loads the output register.
// Stall: the output register is backed by a one-entry skid buffer. While the
//   receiver stalls, the pipeline keeps moving until a result lands in the
//   skid entry; then req_stall rises (registered) and the whole pipe holds.
//   Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and both output
//   entries by clearing their valid bits; the data registers are not reset.
`default_nettype none

module signed_unsigned_divmod32_unit #(
   parameter int WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic [sudm_pkg::FIELD_W-1:0]  req_divisor,
   input  logic [sudm_pkg::FIELD_W-1:0]  req_dividend,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [sudm_pkg::FIELD_W-1:0]  rsp_quotient,
   output logic [sudm_pkg::FIELD_W-1:0]  rsp_remainder,
   output logic                          rsp_divide_by_zero
);
   import sudm_pkg::*;

`include "signed_unsigned_divmod32_unit_assert.svh"

   // global pipe advance; held only while the skid entry is occupied
   logic enable;

   // ---------------- operand stage ----------------
   logic [WIDTH-1:0] d_w;
   logic [WIDTH-1:0] n_w;
   logic             dneg;
   logic             nneg;
   ctrl_type         ctrl0_in;
   logic [WIDTH-1:0] den0_in;
   logic [WIDTH-1:0] acc0_in;

   ctrl_type         ctrl0_ff;
   logic [WIDTH-1:0] den0_ff;
   logic [WIDTH-1:0] acc0_ff;

   always_comb begin
      // fields are resized to the datapath width (zero-extend or truncate)
      d_w  = WIDTH'(req_divisor);
      n_w  = WIDTH'(req_dividend);
      dneg = req_kind & d_w[WIDTH-1];
      nneg = req_kind & n_w[WIDTH-1];
      den0_in = dneg ? (~d_w + WIDTH'(1)) : d_w;
      acc0_in = nneg ? (~n_w + WIDTH'(1)) : n_w;
      ctrl0_in.valid = req_valid;
      ctrl0_in.qneg  = dneg ^ nneg;
      ctrl0_in.rneg  = nneg;
      ctrl0_in.dz    = (d_w == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else if (enable) begin
         ctrl0_ff <= ctrl0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den0_ff <= den0_in;
         acc0_ff <= acc0_in;
      end
   end

   // ---------------- restoring steps ----------------
   // acc holds the unused dividend bits on top and quotient bits from below
   ctrl_type         ctrl_s [WIDTH+1];
   logic [WIDTH-1:0] rem_s  [WIDTH+1];
   logic [WIDTH-1:0] acc_s  [WIDTH+1];
   logic [WIDTH-1:0] den_s  [WIDTH+1];

   assign ctrl_s[0] = ctrl0_ff;
   assign rem_s[0]  = '0;
   assign acc_s[0]  = acc0_ff;
   assign den_s[0]  = den0_ff;

   for (genvar k = 0; k < WIDTH; k++) begin : g_step
      sudm_div_step #(
         .WIDTH (WIDTH)
      ) u_step (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .prev_ctrl  (ctrl_s[k]),
         .prev_rem   (rem_s[k]),
         .prev_acc   (acc_s[k]),
         .prev_den   (den_s[k]),
         .stage_ctrl (ctrl_s[k+1]),
         .stage_rem  (rem_s[k+1]),
         .stage_acc  (acc_s[k+1]),
         .stage_den  (den_s[k+1])
      );
   end

   // ---------------- sign fix ----------------
   ctrl_type         last_ctrl;
   logic [WIDTH-1:0] q_w;
   logic [WIDTH-1:0] r_w;
   logic [FIELD_W-1:0] fin_q;
   logic [FIELD_W-1:0] fin_r;

   always_comb begin
      last_ctrl = ctrl_s[WIDTH];
      q_w = last_ctrl.qneg ? (~acc_s[WIDTH] + WIDTH'(1)) : acc_s[WIDTH];
      r_w = last_ctrl.rneg ? (~rem_s[WIDTH] + WIDTH'(1)) : rem_s[WIDTH];
      if (last_ctrl.dz) begin
         q_w = '0;
         r_w = '0;
      end
      fin_q = FIELD_W'(q_w);
      fin_r = FIELD_W'(r_w);
   end

   // ---------------- output register and skid entry ----------------
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_q_ff;
   logic [FIELD_W-1:0] rsp_r_ff;
   logic               rsp_dz_ff;
   logic               skid_full_ff;
   logic [FIELD_W-1:0] skid_q_ff;
   logic [FIELD_W-1:0] skid_r_ff;
   logic               skid_dz_ff;
   logic               take;

   assign enable = ~skid_full_ff;
   assign take   = rsp_valid_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         priority if (skid_full_ff) begin
            // pipe is frozen; drain skid into the output register
            if (take) begin
               rsp_valid_ff <= 1'b1;
               skid_full_ff <= 1'b0;
            end
         end else if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= last_ctrl.valid;
         end else begin
            // output held by the receiver; a result arriving parks in skid
            skid_full_ff <= last_ctrl.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      priority if (skid_full_ff) begin
         if (take) begin
            rsp_q_ff  <= skid_q_ff;
            rsp_r_ff  <= skid_r_ff;
            rsp_dz_ff <= skid_dz_ff;
         end
      end else if (!rsp_valid_ff || take) begin
         rsp_q_ff  <= fin_q;
         rsp_r_ff  <= fin_r;
         rsp_dz_ff <= last_ctrl.dz;
      end else begin
         skid_q_ff  <= fin_q;
         skid_r_ff  <= fin_r;
         skid_dz_ff <= last_ctrl.dz;
      end
   end

   assign req_stall          = skid_full_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_quotient       = rsp_q_ff;
   assign rsp_remainder      = rsp_r_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

   // ---------------- checks ----------------
   `SUDM_ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_full_ff, rsp_valid_ff)
   `SUDM_ASSERT_NEXT(a_skid_holds, clock, reset, skid_full_ff && rsp_stall, skid_full_ff)
   `SUDM_ASSERT_IMPLIES(a_dz_zero, clock, reset, rsp_valid_ff && rsp_dz_ff, ~|{rsp_q_ff, rsp_r_ff})

endmodule

`default_nettype wire
